FILE: rtl/core/pbws_pkg.sv
// Shared types and constants for the protobuf wire stream parser.
`timescale 1ns / 1ps
`default_nettype none
package pbws_pkg;

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_VARVAL  = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_FIXED   = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   localparam logic [2:0] EV_VARINT  = 3'd0;
   localparam logic [2:0] EV_LEN_HDR = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_FIXED64 = 3'd3;
   localparam logic [2:0] EV_FIXED32 = 3'd4;
   localparam logic [2:0] EV_ERROR   = 3'd5;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_OVERLONG  = 3'd1;
   localparam logic [2:0] ERR_BAD_WIRE  = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN     = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   localparam logic [3:0] VARINT_LAST_BYTE = 4'd9;
   localparam logic [6:0] VARINT_DIGIT     = 7'd7;
   localparam int         FIXED64_BYTES    = 8;
   localparam int         FIXED32_BYTES    = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] field_id;
      logic [2:0]  wire_kind;
      logic [63:0] field_value;
      logic [2:0]  error_code;
      logic        at_message_end;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/pbws_if.sv
// Valid/ready channel interfaces for message bytes and parse events.
`timescale 1ns / 1ps
`default_nettype none
interface pbws_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink (input valid, input data_byte, input message_end, output ready);
endinterface

interface pbws_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] field_id;
   logic [2:0]  wire_kind;
   logic [63:0] field_value;
   logic [2:0]  error_code;
   logic        at_message_end;

   modport source (output valid, output event_kind, output field_id, output wire_kind,
                   output field_value, output error_code, output at_message_end,
                   input ready);
   modport sink (input valid, input event_kind, input field_id, input wire_kind,
                 input field_value, input error_code, input at_message_end,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/protobuf_wire_stream_parser_core.sv
// Top level of the protobuf wire format stream parser.
// The request channel carries one message byte per request, with message_end set
// on the last byte of each message. The response channel carries parse events:
// varint values, length headers, payload bytes, fixed field skips and errors.
// A byte that completes nothing gives no response.
// A request is registered at the input, decoded against the parse state when
// the output register is free or being emptied, and its event is registered
// at the output. One request is accepted per cycle for as long as the output
// register is free or being emptied; the rate is set by the decode step that
// updates the parse state.
// When the receiver stalls, the pending event holds in the output register, one
// more request waits in the input register, and ready then drops.
// Reset clears both registers and returns the parser to expecting a tag.
// After an error, bytes are dropped silently up to the next message end.
// LEN_BITS sets the largest accepted length: below 2 to the power LEN_BITS.
`timescale 1ns / 1ps
`default_nettype none
module protobuf_wire_stream_parser_core #(
   parameter int LEN_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pbws_req_if.sink   req_chan,
   pbws_rsp_if.source rsp_chan
);
   import pbws_pkg::*;

   req_type held_req;
   logic    held_valid;
   logic    can_load;
   logic    advance;
   logic    result_valid;
   rsp_type result;

   assign advance = held_valid && can_load;

   pbws_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .held_req   (held_req),
      .held_valid (held_valid)
   );

   pbws_decoder #(
      .LEN_BITS (LEN_BITS)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cur_req      (held_req),
      .result_valid (result_valid),
      .result       (result)
   );

   pbws_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .result_valid (result_valid),
      .result       (result),
      .can_load     (can_load),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: rtl/core/pbws_in_stage.sv
// Input register that holds one request byte until the decoder takes it.
`timescale 1ns / 1ps
`default_nettype none
module pbws_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   pbws_req_if.sink              req_chan,
   input  wire logic             advance,
   output pbws_pkg::req_type     held_req,
   output logic                  held_valid
);
   import pbws_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   req_type req_in;
   logic    take;

   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      req_in = req_ff;
      if (take) begin
         valid_in = 1'b1;
         req_in.data_byte = req_chan.data_byte;
         req_in.message_end = req_chan.message_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign held_req = req_ff;
   assign held_valid = valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pbws_decoder.sv
// Parse state and the per-byte wire format decode step.
`timescale 1ns / 1ps
`default_nettype none
module pbws_decoder #(
   parameter int LEN_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire pbws_pkg::req_type cur_req,
   output logic                  result_valid,
   output pbws_pkg::rsp_type     result
);
   import pbws_pkg::*;

   localparam logic [63:0] LenMask = ~((64'd1 << LEN_BITS) - 64'd1);

   phase_type             phase_ff, phase_in;
   logic [63:0]           acc_ff, acc_in;
   logic [3:0]            shift_count_ff, shift_count_in;
   logic [31:0]           field_ff, field_in;
   logic [2:0]            wire_ff, wire_in;
   logic [LEN_BITS-1:0]   bytes_left_ff, bytes_left_in;

   logic [5:0]            shift_amt;
   logic [63:0]           acc_new;
   logic [3:0]            shift_inc;
   logic                  is_long;
   logic                  is_more;
   logic                  end_flag;
   logic [31:0]           tag_field;
   logic [2:0]            tag_wire;
   logic                  wire_ok;
   logic                  len_over;
   logic                  len_zero;
   logic [LEN_BITS-1:0]   left_dec;
   logic                  left_last;

   assign end_flag = cur_req.message_end;
   assign shift_amt = 6'(7'(shift_count_ff) * VARINT_DIGIT);
   assign acc_new = acc_ff | ({57'd0, cur_req.data_byte[6:0]} << shift_amt);
   assign shift_inc = shift_count_ff + 4'd1;
   assign is_long = cur_req.data_byte[7] && (shift_count_ff == VARINT_LAST_BYTE);
   assign is_more = cur_req.data_byte[7] && !is_long;
   assign tag_field = acc_new[34:3];
   assign tag_wire = acc_new[2:0];
   assign wire_ok = (tag_wire == WIRE_VARINT) || (tag_wire == WIRE_FIXED64) ||
                    (tag_wire == WIRE_LEN) || (tag_wire == WIRE_FIXED32);
   assign len_over = |(acc_new & LenMask);
   assign len_zero = (acc_new == 64'd0);
   assign left_dec = bytes_left_ff - LEN_BITS'(1);
   assign left_last = (left_dec == '0);

   // Next parse state.
   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      shift_count_in = shift_count_ff;
      field_in = field_ff;
      wire_in = wire_ff;
      bytes_left_in = bytes_left_ff;
      unique case (phase_ff) inside
         PH_DISCARD: begin
            if (end_flag) begin
               phase_in = PH_TAG;
               acc_in = '0;
               shift_count_in = '0;
            end
         end
         PH_VARVAL, PH_LEN: begin
            if (is_long || (is_more && end_flag) ||
                (!is_more && phase_ff == PH_LEN && !len_over && !len_zero && end_flag)) begin
               phase_in = end_flag ? PH_TAG : PH_DISCARD;
               acc_in = '0;
               shift_count_in = '0;
            end else if (is_more) begin
               acc_in = acc_new;
               shift_count_in = shift_inc;
            end else if (phase_ff == PH_VARVAL || len_over || len_zero) begin
               phase_in = (phase_ff == PH_LEN && len_over && !end_flag) ? PH_DISCARD : PH_TAG;
               acc_in = '0;
               shift_count_in = '0;
            end else begin
               acc_in = acc_new;
               bytes_left_in = acc_new[LEN_BITS-1:0];
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD, PH_FIXED: begin
            bytes_left_in = left_dec;
            if (left_last || end_flag) begin
               phase_in = PH_TAG;
               acc_in = '0;
               shift_count_in = '0;
            end
         end
         PH_TAG: begin
            if (is_long || (is_more && end_flag)) begin
               phase_in = end_flag ? PH_TAG : PH_DISCARD;
               acc_in = '0;
               shift_count_in = '0;
            end else if (is_more) begin
               acc_in = acc_new;
               shift_count_in = shift_inc;
            end else begin
               field_in = tag_field;
               wire_in = tag_wire;
               acc_in = '0;
               shift_count_in = '0;
               if (!wire_ok) begin
                  phase_in = end_flag ? PH_TAG : PH_DISCARD;
               end else if (end_flag) begin
                  phase_in = PH_TAG;
               end else if (tag_wire == WIRE_VARINT) begin
                  phase_in = PH_VARVAL;
               end else if (tag_wire == WIRE_LEN) begin
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_FIXED;
                  bytes_left_in = (tag_wire == WIRE_FIXED64) ? LEN_BITS'(FIXED64_BYTES)
                                                             : LEN_BITS'(FIXED32_BYTES);
               end
            end
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase
   end

   // Event produced for the current byte.
   always_comb begin
      result_valid = 1'b0;
      result.event_kind = EV_ERROR;
      result.field_id = field_ff;
      result.wire_kind = wire_ff;
      result.field_value = '0;
      result.error_code = ERR_NONE;
      result.at_message_end = end_flag;
      unique case (phase_ff) inside
         PH_DISCARD: begin
            result_valid = 1'b0;
         end
         PH_VARVAL, PH_LEN: begin
            if (is_long) begin
               result_valid = 1'b1;
               result.error_code = ERR_OVERLONG;
            end else if (is_more) begin
               result_valid = end_flag;
               result.error_code = ERR_TRUNCATED;
            end else if (phase_ff == PH_VARVAL) begin
               result_valid = 1'b1;
               result.event_kind = EV_VARINT;
               result.field_value = acc_new;
            end else if (len_over) begin
               result_valid = 1'b1;
               result.error_code = ERR_TOO_LONG;
            end else if (!len_zero && end_flag) begin
               result_valid = 1'b1;
               result.error_code = ERR_TRUNCATED;
            end else begin
               result_valid = 1'b1;
               result.event_kind = EV_LEN_HDR;
               result.field_value = acc_new;
            end
         end
         PH_PAYLOAD: begin
            result_valid = 1'b1;
            if (!left_last && end_flag) begin
               result.error_code = ERR_TRUNCATED;
            end else begin
               result.event_kind = EV_PAYLOAD;
               result.field_value = {56'd0, cur_req.data_byte};
            end
         end
         PH_FIXED: begin
            if (left_last) begin
               result_valid = 1'b1;
               result.event_kind = (wire_ff == WIRE_FIXED64) ? EV_FIXED64 : EV_FIXED32;
            end else if (end_flag) begin
               result_valid = 1'b1;
               result.error_code = ERR_TRUNCATED;
            end
         end
         PH_TAG: begin
            if (is_long || is_more) begin
               result_valid = is_long || end_flag;
               result.field_id = '0;
               result.wire_kind = '0;
               result.error_code = is_long ? ERR_OVERLONG : ERR_TRUNCATED;
            end else begin
               result_valid = !wire_ok || end_flag;
               result.field_id = tag_field;
               result.wire_kind = tag_wire;
               result.error_code = wire_ok ? ERR_TRUNCATED : ERR_BAD_WIRE;
            end
         end
         default: begin
            result_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         acc_ff <= '0;
         shift_count_ff <= '0;
         field_ff <= '0;
         wire_ff <= '0;
         bytes_left_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         shift_count_ff <= shift_count_in;
         field_ff <= field_in;
         wire_ff <= wire_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   a_discard_silent: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_DISCARD |-> !result_valid)
      else $error("result produced while discarding");

   a_error_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      step && result_valid && result.event_kind == EV_ERROR
      |=> phase_ff == PH_TAG || phase_ff == PH_DISCARD)
      else $error("error did not return the parser to tag or discard");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      shift_count_ff <= VARINT_LAST_BYTE)
      else $error("varint byte count out of range");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD || phase_ff == PH_FIXED |-> bytes_left_ff != '0)
      else $error("byte counter empty inside a field body");

endmodule
`default_nettype wire

FILE: rtl/core/pbws_out_stage.sv
// Result register that holds one event until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module pbws_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic             result_valid,
   input  wire pbws_pkg::rsp_type result,
   output logic                  can_load,
   pbws_rsp_if.source            rsp_chan
);
   import pbws_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      rsp_in = rsp_ff;
      if (load) begin
         valid_in = result_valid;
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.event_kind = rsp_ff.event_kind;
   assign rsp_chan.field_id = rsp_ff.field_id;
   assign rsp_chan.wire_kind = rsp_ff.wire_kind;
   assign rsp_chan.field_value = rsp_ff.field_value;
   assign rsp_chan.error_code = rsp_ff.error_code;
   assign rsp_chan.at_message_end = rsp_ff.at_message_end;

endmodule
`default_nettype wire

FILE: bench/protobuf_wire_stream_parser_core_tb.sv
// Self-checking testbench for the protobuf wire stream parser core.
`timescale 1ns / 1ps
module protobuf_wire_stream_parser_core_tb;
   import pbws_pkg::*;

   localparam int LEN_LIMIT_BITS = 32;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;

   localparam int VT_DONE = 0;
   localparam int VT_MORE = 1;
   localparam int VT_LONG = 2;

   localparam logic [2:0] WIRE_START_GROUP = 3'd3;
   localparam logic [2:0] WIRE_END_GROUP   = 3'd4;
   localparam logic [2:0] WIRE_RESERVED_6  = 3'd6;
   localparam logic [2:0] WIRE_RESERVED_7  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbws_req_if req_bus ();
   pbws_rsp_if rsp_bus ();

   protobuf_wire_stream_parser_core #(
      .LEN_BITS(LEN_LIMIT_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   phase_type   pr_phase = PH_TAG;
   logic [63:0] pr_acc   = '0;
   logic [3:0]  pr_shift = '0;
   logic [31:0] pr_field = '0;
   logic [2:0]  pr_wire  = '0;
   logic [63:0] pr_left  = '0;

   rsp_type expected_events[$];

   int mismatches     = 0;
   int bytes_sent     = 0;
   int messages_sent  = 0;
   int events_checked = 0;
   int error_events   = 0;
   int cycle_count    = 0;
   bit send_idle_on   = 1'b1;
   bit recv_idle_on   = 1'b1;
   int stall_request  = 0;

   function automatic void restart_varint();
      pr_acc   = '0;
      pr_shift = '0;
   endfunction

   function automatic void go_to_tag();
      pr_phase = PH_TAG;
      restart_varint();
   endfunction

   function automatic int take_varint_byte(input logic [7:0] b);
      logic [5:0] sh;
      sh = 6'((int'(pr_shift) * 7) % 64);
      pr_acc = pr_acc | ({57'd0, b[6:0]} << sh);
      if (!b[7]) return VT_DONE;
      pr_shift = pr_shift + 4'd1;
      if (int'(pr_shift) * 7 > 63) return VT_LONG;
      return VT_MORE;
   endfunction

   function automatic rsp_type make_event(input logic [2:0] kind, input logic [31:0] fid,
                                          input logic [2:0] wk, input logic [63:0] val,
                                          input logic [2:0] err, input logic e);
      rsp_type ev;
      ev.event_kind     = kind;
      ev.field_id       = fid;
      ev.wire_kind      = wk;
      ev.field_value    = val;
      ev.error_code     = err;
      ev.at_message_end = e;
      return ev;
   endfunction

   function automatic bit parse_error(input logic [2:0] err, input logic [31:0] fid,
                                      input logic [2:0] wk, input logic e,
                                      output rsp_type ev);
      ev = make_event(EV_ERROR, fid, wk, 64'd0, err, e);
      if (e) begin
         go_to_tag();
      end else begin
         pr_phase = PH_DISCARD;
         restart_varint();
      end
      return 1'b1;
   endfunction

   function automatic bit predict_parse_event(input logic [7:0] b, input logic e,
                                              output rsp_type ev);
      int r;
      ev = '0;
      case (pr_phase) inside
         PH_DISCARD: begin
            if (e) go_to_tag();
            return 1'b0;
         end
         PH_VARVAL, PH_LEN: begin
            r = take_varint_byte(b);
            if (r == VT_LONG) return parse_error(ERR_OVERLONG, pr_field, pr_wire, e, ev);
            if (r == VT_MORE) begin
               if (e) return parse_error(ERR_TRUNCATED, pr_field, pr_wire, e, ev);
               return 1'b0;
            end
            if (pr_phase == PH_VARVAL) begin
               ev = make_event(EV_VARINT, pr_field, pr_wire, pr_acc, ERR_NONE, e);
               go_to_tag();
               return 1'b1;
            end
            if (LEN_LIMIT_BITS < 64 && (pr_acc >> LEN_LIMIT_BITS) != 0)
               return parse_error(ERR_TOO_LONG, pr_field, pr_wire, e, ev);
            if (pr_acc == 0) begin
               ev = make_event(EV_LEN_HDR, pr_field, pr_wire, 64'd0, ERR_NONE, e);
               go_to_tag();
               return 1'b1;
            end
            if (e) return parse_error(ERR_TRUNCATED, pr_field, pr_wire, e, ev);
            ev = make_event(EV_LEN_HDR, pr_field, pr_wire, pr_acc, ERR_NONE, e);
            pr_left  = pr_acc;
            pr_phase = PH_PAYLOAD;
            return 1'b1;
         end
         PH_PAYLOAD: begin
            pr_left = pr_left - 64'd1;
            if (pr_left == 0) begin
               ev = make_event(EV_PAYLOAD, pr_field, pr_wire, {56'd0, b}, ERR_NONE, e);
               go_to_tag();
               return 1'b1;
            end
            if (e) return parse_error(ERR_TRUNCATED, pr_field, pr_wire, e, ev);
            ev = make_event(EV_PAYLOAD, pr_field, pr_wire, {56'd0, b}, ERR_NONE, e);
            return 1'b1;
         end
         PH_FIXED: begin
            pr_left = pr_left - 64'd1;
            if (pr_left == 0) begin
               ev = make_event((pr_wire == WIRE_FIXED64) ? EV_FIXED64 : EV_FIXED32,
                               pr_field, pr_wire, 64'd0, ERR_NONE, e);
               go_to_tag();
               return 1'b1;
            end
            if (e) return parse_error(ERR_TRUNCATED, pr_field, pr_wire, e, ev);
            return 1'b0;
         end
         default: begin
            r = take_varint_byte(b);
            if (r == VT_LONG) return parse_error(ERR_OVERLONG, '0, '0, e, ev);
            if (r == VT_MORE) begin
               if (e) return parse_error(ERR_TRUNCATED, '0, '0, e, ev);
               return 1'b0;
            end
            pr_field = pr_acc[34:3];
            pr_wire  = pr_acc[2:0];
            if (pr_wire != WIRE_VARINT && pr_wire != WIRE_FIXED64 &&
                pr_wire != WIRE_LEN && pr_wire != WIRE_FIXED32)
               return parse_error(ERR_BAD_WIRE, pr_field, pr_wire, e, ev);
            if (e) return parse_error(ERR_TRUNCATED, pr_field, pr_wire, e, ev);
            restart_varint();
            if (pr_wire == WIRE_VARINT) begin
               pr_phase = PH_VARVAL;
            end else if (pr_wire == WIRE_LEN) begin
               pr_phase = PH_LEN;
            end else begin
               pr_left  = (pr_wire == WIRE_FIXED64) ? 64'(FIXED64_BYTES) : 64'(FIXED32_BYTES);
               pr_phase = PH_FIXED;
            end
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d events outstanding", expected_events.size());
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : check_events
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("event with none expected, kind", 64'(rsp_bus.event_kind), 64'd0);
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 64'(rsp_bus.event_kind), 64'(want.event_kind));
            check_field("field_id", 64'(rsp_bus.field_id), 64'(want.field_id));
            check_field("wire_kind", 64'(rsp_bus.wire_kind), 64'(want.wire_kind));
            check_field("field_value", rsp_bus.field_value, want.field_value);
            check_field("error_code", 64'(rsp_bus.error_code), 64'(want.error_code));
            check_field("at_message_end", 64'(rsp_bus.at_message_end),
                        64'(want.at_message_end));
            events_checked++;
            if (want.event_kind == EV_ERROR) error_events++;
         end
      end
   end

   initial begin : drive_ready
      forever begin
         if (stall_request > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_request) @(posedge clock);
            stall_request = 0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic e);
      rsp_type ev;
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.message_end <= e;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_parse_event(b, e, ev))
         expected_events.insert(expected_events.size(), ev);
      bytes_sent++;
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_message(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
      messages_sent++;
   endtask

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int rand_pad();
      if ($urandom_range(0, 7) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [60:0] rand_field_num();
      int pick;
      logic [63:0] r;
      pick = $urandom_range(0, 9);
      r = rand64();
      if (pick < 6) return 61'($urandom_range(0, 15));
      if (pick < 9) return {29'd0, r[31:0]};
      return r[60:0];
   endfunction

   function automatic logic [2:0] pick_bad_wire();
      case ($urandom_range(0, 3))
         0: return WIRE_START_GROUP;
         1: return WIRE_END_GROUP;
         2: return WIRE_RESERVED_6;
         default: return WIRE_RESERVED_7;
      endcase
   endfunction

   task automatic add_byte(ref logic [7:0] q[$], input logic [7:0] b);
      q.insert(q.size(), b);
   endtask

   // Padding adds redundant continuation bytes, never beyond ten bytes in total.
   task automatic push_varint(ref logic [7:0] q[$], input logic [63:0] v, input int pad);
      logic [63:0] rest;
      logic [7:0] b;
      int len;
      int extra;
      rest = v;
      len = 0;
      do begin
         rest = rest >> 7;
         len++;
      end while (rest != 0);
      extra = (pad > 10 - len) ? 10 - len : pad;
      rest = v;
      for (int i = 0; i < len; i++) begin
         b = {1'b0, rest[6:0]};
         rest = rest >> 7;
         if (i < len - 1 || extra > 0) b[7] = 1'b1;
         add_byte(q, b);
      end
      for (int i = 0; i < extra; i++) add_byte(q, (i == extra - 1) ? 8'h00 : 8'h80);
   endtask

   task automatic push_tag(ref logic [7:0] q[$], input logic [60:0] field_num,
                           input logic [2:0] wire_code, input int pad);
      push_varint(q, {field_num, wire_code}, pad);
   endtask

   task automatic build_random_message(ref logic [7:0] q[$]);
      int fields;
      int pick;
      int len;
      int keep;
      logic [63:0] v;
      fields = $urandom_range(1, 5);
      repeat (fields) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            push_tag(q, rand_field_num(), WIRE_VARINT, rand_pad());
            push_varint(q, rand64() >> $urandom_range(0, 64), rand_pad());
         end else if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            push_tag(q, rand_field_num(), WIRE_LEN, rand_pad());
            push_varint(q, 64'(len), rand_pad());
            repeat (len) add_byte(q, 8'($urandom()));
         end else if (pick < 65) begin
            push_tag(q, rand_field_num(), WIRE_FIXED64, rand_pad());
            repeat (FIXED64_BYTES) add_byte(q, 8'($urandom()));
         end else if (pick < 75) begin
            push_tag(q, rand_field_num(), WIRE_FIXED32, rand_pad());
            repeat (FIXED32_BYTES) add_byte(q, 8'($urandom()));
         end else if (pick < 80) begin
            push_tag(q, rand_field_num(), pick_bad_wire(), rand_pad());
            repeat ($urandom_range(0, 3)) add_byte(q, 8'($urandom()));
         end else if (pick < 85) begin
            if ($urandom_range(0, 1) == 1)
               push_tag(q, rand_field_num(),
                        ($urandom_range(0, 1) == 1) ? WIRE_VARINT : WIRE_LEN, 0);
            repeat (10) add_byte(q, 8'h80 | 8'($urandom_range(0, 127)));
            repeat ($urandom_range(0, 3)) add_byte(q, 8'($urandom()));
         end else if (pick < 90) begin
            v = rand64() | (64'd1 << $urandom_range(LEN_LIMIT_BITS, 63));
            push_tag(q, rand_field_num(), WIRE_LEN, 0);
            push_varint(q, v, 0);
            repeat ($urandom_range(0, 3)) add_byte(q, 8'($urandom()));
         end else begin
            repeat ($urandom_range(1, 4)) add_byte(q, 8'($urandom()));
         end
      end
      if (q.size() > 1 && $urandom_range(0, 6) == 0) begin
         keep = $urandom_range(1, q.size() - 1);
         while (q.size() > keep) void'(q.pop_back());
      end
   endtask

   task automatic test_field_kinds();
      logic [7:0] q[$];
      push_tag(q, 61'd1, WIRE_VARINT, 0);
      push_varint(q, 64'd0, 0);
      push_tag(q, 61'd2, WIRE_VARINT, 0);
      push_varint(q, '1, 0);
      // Bits above bit 63 in the tenth byte are dropped.
      push_tag(q, 61'd3, WIRE_VARINT, 0);
      repeat (9) add_byte(q, 8'hFF);
      add_byte(q, 8'h7F);
      push_tag(q, 61'hFFFF_FFFF, WIRE_LEN, 0);
      push_varint(q, 64'd0, 0);
      push_tag(q, {61{1'b1}}, WIRE_LEN, 0);
      push_varint(q, 64'd2, 0);
      add_byte(q, 8'h00);
      add_byte(q, 8'hFF);
      push_tag(q, 61'd0, WIRE_FIXED64, 0);
      repeat (FIXED64_BYTES) add_byte(q, 8'($urandom()));
      push_tag(q, 61'd6, WIRE_FIXED32, 0);
      repeat (FIXED32_BYTES) add_byte(q, 8'($urandom()));
      send_message(q);
   endtask

   task automatic test_error_cases();
      logic [7:0] q[$];
      repeat (10) add_byte(q, 8'h80);
      add_byte(q, 8'h08);
      add_byte(q, 8'h01);
      send_message(q);
      q = '{8'h08};
      repeat (10) add_byte(q, 8'hFF);
      send_message(q);
      q = '{8'h0B, 8'h00};
      send_message(q);
      q = '{8'h0C};
      send_message(q);
      q = '{8'h0E, 8'h01, 8'h02};
      send_message(q);
      q = '{8'h0F};
      send_message(q);
      q = '{8'h88};
      send_message(q);
      q = '{8'h08};
      send_message(q);
      q = '{8'h08, 8'h80};
      send_message(q);
      q = '{8'h12, 8'h03};
      send_message(q);
      q = '{8'h12, 8'h02, 8'hAA};
      send_message(q);
      q = '{8'h09, 8'h00, 8'h00};
      send_message(q);
      q = '{8'h2D, 8'h11};
      send_message(q);
      q = '{8'h12, 8'h00};
      send_message(q);
      q.delete();
      push_tag(q, 61'd2, WIRE_LEN, 0);
      push_varint(q, 64'h1_0000_0000, 0);
      add_byte(q, 8'h01);
      send_message(q);
      q.delete();
      push_tag(q, 61'd2, WIRE_LEN, 0);
      push_varint(q, 64'hFFFF_FFFF, 0);
      send_message(q);
      q = '{8'h08, 8'h2A};
      send_message(q);
   endtask

   task automatic test_receiver_stall();
      logic [7:0] q[$];
      push_tag(q, 61'd10, WIRE_LEN, 0);
      push_varint(q, 64'd60, 0);
      repeat (60) add_byte(q, 8'($urandom()));
      send_idle_on = 1'b0;
      stall_request = 150;
      send_message(q);
      pause_until_drained();
      send_idle_on = 1'b1;
   endtask

   task automatic test_random_messages(input int target, input bit idle_on);
      logic [7:0] q[$];
      int start;
      send_idle_on = idle_on;
      recv_idle_on = idle_on;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         q.delete();
         build_random_message(q);
         send_message(q);
      end
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.message_end <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_field_kinds();
      test_error_cases();
      test_receiver_stall();
      test_random_messages(640, 1'b1);
      test_random_messages(220, 1'b0);
      pause_until_drained();
      $display("covered %0d messages of %0d bytes, %0d events checked, %0d of them errors",
               messages_sent, bytes_sent, events_checked, error_events);
      $display("included every field kind, every error kind, a long output stall and streaming");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/pbws_pkg.sv
rtl/core/pbws_if.sv
rtl/core/pbws_in_stage.sv
rtl/core/pbws_decoder.sv
rtl/core/pbws_out_stage.sv
rtl/core/protobuf_wire_stream_parser_core.sv
bench/protobuf_wire_stream_parser_core_tb.sv
